### design/dwgf_pkg.sv
// ----------------------------------------------------------------------------
// dwgf_pkg
// Shared types and constants of the diagonal weighted glow filter.
// ----------------------------------------------------------------------------
package dwgf_pkg;

  localparam int unsigned FIELD_BITS   = 16;
  localparam int unsigned CFG_DIM_BITS = 11;
  localparam int unsigned DIM_RESET    = 64;

  // tap weights, in hundredths
  localparam int unsigned W_CENTRE = 30;
  localparam int unsigned W_DIAG   = 16;
  localparam int unsigned W_DEN    = 100;

  localparam int unsigned TAPS = 5;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = 3;
  localparam int unsigned FIFO_CW    = 4;

  // register index decoded from paddr[2]
  localparam logic REG_IMAGE_DIM = 1'b0;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_DRAIN = 1'b1
  } kind_e;

  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
  } border_t;

endpackage

### design/dwgf_ram.sv
// ----------------------------------------------------------------------------
// dwgf_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module dwgf_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/dwgf_scale.sv
// ----------------------------------------------------------------------------
// dwgf_scale
// Two-stage constant scaler: q = floor(v * NUM / DEN), reciprocal multiply
// followed by a single remainder correction.
// ----------------------------------------------------------------------------
module dwgf_scale #(
  parameter int unsigned CB  = 16,
  parameter int unsigned NUM = 30,
  parameter int unsigned DEN = 100
) (
  input  logic          clk_i,
  input  logic [CB-1:0] v_i,
  output logic [CB-1:0] q_o
);

  localparam int unsigned SH  = CB + 2;
  localparam int unsigned PRW = CB + SH;
  localparam int unsigned RMW = CB + 8;
  localparam logic [SH-1:0] RECIP = SH'((64'(NUM) << SH) / 64'(DEN));

  logic [PRW-1:0] prod;
  logic [RMW-1:0] rem;
  logic [CB-1:0]  v_q;
  logic [CB-1:0]  est_q;
  logic [CB-1:0]  q_q;

  assign prod = PRW'(v_i) * PRW'(RECIP);

  // estimate is low by at most one
  assign rem = RMW'(v_q) * RMW'(NUM) - RMW'(est_q) * RMW'(DEN);

  always_ff @(posedge clk_i) begin
    v_q   <= v_i;
    est_q <= prod[PRW-1:SH];
    q_q   <= (rem >= RMW'(DEN)) ? est_q + CB'(1) : est_q;
  end

  assign q_o = q_q;

endmodule

### design/diagonal_weighted_glow_filter_core.sv
// ----------------------------------------------------------------------------
// diagonal_weighted_glow_filter_core
// Streaming 3x3 diagonal glow filter over a square RGB image.
//
// Pixels of a square image of side image_dim arrive on the input channel in
// raster order, one request per pixel (kind = pixel). Each result is
// floor(c*30/100) plus floor(n*16/100) for every diagonal neighbour inside
// the image. The result for raster index k is produced by input request
// k+image_dim+1, so after the frame the host sends image_dim+1 drain
// requests; drains before the frame is complete are taken and dropped.
// frame_last marks the final pixel, after which a new frame starts.
// Throughput is one request per cycle while in_ready_o is high. A request passes
// through the line store read, the window stage, the two-stage weight scalers
// and the queue write before its result shows on the output. Results wait
// in an 8-entry queue; in_ready_o falls while 8 results are in flight or
// queued, so a stalled receiver holds the input back without loss. Reset sets
// image_dim to 64 and the frame position to zero; the line store needs no
// clearing pass. Writing image_dim also restarts the frame.
// ----------------------------------------------------------------------------
module diagonal_weighted_glow_filter_core
  import dwgf_pkg::*;
#(
  parameter int unsigned MAX_DIM      = 1024,
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic [FIELD_BITS-1:0] pixel_red_i,
  input  logic [FIELD_BITS-1:0] pixel_green_i,
  input  logic [FIELD_BITS-1:0] pixel_blue_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [FIELD_BITS-1:0] out_red_o,
  output logic [FIELD_BITS-1:0] out_green_o,
  output logic [FIELD_BITS-1:0] out_blue_o,
  output logic                  frame_last_o
);

  localparam int unsigned CB      = CHANNEL_BITS;
  localparam int unsigned AW      = $clog2(MAX_DIM);
  localparam int unsigned DW      = $clog2(MAX_DIM + 1);
  localparam int unsigned RW      = $clog2(MAX_DIM + 2);
  localparam int unsigned PW      = 3 * CB;
  localparam int unsigned MW      = 2 * PW;
  localparam int unsigned SW      = CB + 3;
  localparam int unsigned DIM_RST = (DIM_RESET > MAX_DIM) ? MAX_DIM : DIM_RESET;

  localparam int unsigned ROW_TOP = 2;
  localparam int unsigned ROW_MID = 1;
  localparam int unsigned ROW_BOT = 0;

  localparam int unsigned TAP_C  = 0;
  localparam int unsigned TAP_TL = 1;
  localparam int unsigned TAP_TR = 2;
  localparam int unsigned TAP_BL = 3;
  localparam int unsigned TAP_BR = 4;

  // configuration
  logic                    cfg_wr;
  logic [CFG_DIM_BITS-1:0] cfg_val;
  logic [DW-1:0]           dim_new;
  logic [CFG_DIM_BITS-1:0] cfg_q;
  logic [DW-1:0]           dim_q;
  logic [DW-1:0]           dim_last;

  // frame position
  logic [RW-1:0] in_row_q, in_row_d;
  logic [AW-1:0] in_col_q, in_col_d;
  logic [AW-1:0] out_r_q, out_r_d;
  logic [AW-1:0] out_c_q, out_c_d;

  logic    req;
  logic    frame_done;
  logic    ignore;
  logic    adv;
  logic    emit;
  logic    col_end;
  logic    out_col_end;
  logic    out_row_end;
  logic    last;
  border_t border;

  // line store and window
  logic [MW-1:0]         ram_rd;
  logic [MW-1:0]         col_rd;
  logic [MW-1:0]         line_wr;
  logic [PW-1:0]         above;
  logic [PW-1:0]         centre;
  logic                  fwd_q;
  logic [MW-1:0]         fwd_data_q;
  logic [2:0][PW-1:0]    win1_q;
  logic [2:0][PW-1:0]    win2_q;

  logic                  s1_valid_q;
  logic [AW-1:0]         s1_col_q;
  logic [PW-1:0]         s1_pix_q;
  logic                  s1_emit_q;
  logic                  s1_last_q;
  border_t               s1_border_q;

  logic                      s2_valid_q;
  logic                      s2_last_q;
  logic [TAPS-1:0][PW-1:0]   s2_tap_q;
  logic                      sa_valid_q, sa_last_q;
  logic                      sb_valid_q, sb_last_q;

  logic [CB-1:0] scaled [TAPS][3];
  logic [SW-1:0] ch_sum [3];
  logic [PW-1:0] res_pix;

  // result queue
  logic [PW:0]          fifo_mem_q [FIFO_DEPTH];
  logic [PW:0]          fifo_rd;
  logic [FIFO_AW-1:0]   wptr_q, rptr_q;
  logic [FIFO_CW-1:0]   fifo_cnt_q;
  logic [FIFO_CW-1:0]   pending_q;
  logic                 push;
  logic                 pop;

  // ---------------------------------------------------------------- config
  assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_IMAGE_DIM);
  assign cfg_val = pwdata[CFG_DIM_BITS-1:0];
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_IMAGE_DIM) ? 32'(cfg_q) : 32'd0;

  always_comb begin
    priority if (cfg_val == '0) begin
      dim_new = DW'(1);
    end else if (32'(cfg_val) > 32'(MAX_DIM)) begin
      dim_new = DW'(MAX_DIM);
    end else begin
      dim_new = DW'(cfg_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_DIM_BITS'(DIM_RESET);
      dim_q <= DW'(DIM_RST);
    end else if (cfg_wr) begin
      cfg_q <= cfg_val;
      dim_q <= dim_new;
    end
  end

  assign dim_last = dim_q - DW'(1);

  // ---------------------------------------------------------- input control
  assign in_ready_o  = pending_q < FIFO_CW'(FIFO_DEPTH);
  assign req         = in_valid_i && in_ready_o;
  assign frame_done  = in_row_q >= RW'(dim_q);
  assign ignore      = (kind_e'(kind_i) == KIND_DRAIN) && !frame_done;
  assign adv         = req && !ignore;
  assign emit        = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
  assign col_end     = DW'(in_col_q) == dim_last;
  assign out_col_end = DW'(out_c_q) == dim_last;
  assign out_row_end = DW'(out_r_q) == dim_last;
  assign last        = emit && out_row_end && out_col_end;

  assign border.up = out_r_q != '0;
  assign border.dn = !out_row_end;
  assign border.lf = out_c_q != '0;
  assign border.rt = !out_col_end;

  always_comb begin
    in_row_d = in_row_q;
    in_col_d = in_col_q;
    out_r_d  = out_r_q;
    out_c_d  = out_c_q;
    priority if (cfg_wr) begin
      in_row_d = '0;
      in_col_d = '0;
      out_r_d  = '0;
      out_c_d  = '0;
    end else if (adv) begin
      if (col_end) begin
        in_col_d = '0;
        in_row_d = in_row_q + RW'(1);
      end else begin
        in_col_d = in_col_q + AW'(1);
      end
      if (emit) begin
        if (out_col_end) begin
          out_c_d = '0;
          out_r_d = out_r_q + AW'(1);
        end else begin
          out_c_d = out_c_q + AW'(1);
        end
      end
      if (last) begin
        in_row_d = '0;
        in_col_d = '0;
        out_r_d  = '0;
        out_c_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q <= '0;
      in_col_q <= '0;
      out_r_q  <= '0;
      out_c_q  <= '0;
    end else begin
      in_row_q <= in_row_d;
      in_col_q <= in_col_d;
      out_r_q  <= out_r_d;
      out_c_q  <= out_c_d;
    end
  end

  // ------------------------------------------------------------ line store
  // each entry holds the two previous rows of one column: {above, centre}
  dwgf_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_DIM)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (line_wr),
    .re_i    (adv),
    .raddr_i (in_col_q),
    .rdata_o (ram_rd)
  );

  assign col_rd  = fwd_q ? fwd_data_q : ram_rd;
  assign above   = col_rd[MW-1:PW];
  assign centre  = col_rd[PW-1:0];
  assign line_wr = {centre, s1_pix_q};

  // write and read of the same column in one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q      <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      fwd_q      <= s1_valid_q && adv && (s1_col_q == in_col_q);
      s1_valid_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= line_wr;
    if (adv) begin
      s1_col_q    <= in_col_q;
      s1_pix_q    <= {pixel_red_i[CB-1:0], pixel_green_i[CB-1:0], pixel_blue_i[CB-1:0]};
      s1_emit_q   <= emit;
      s1_last_q   <= last;
      s1_border_q <= border;
    end
  end

  // ---------------------------------------------------------------- window
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      win2_q          <= win1_q;
      win1_q[ROW_TOP] <= above;
      win1_q[ROW_MID] <= centre;
      win1_q[ROW_BOT] <= s1_pix_q;
    end
    if (s1_valid_q && s1_emit_q) begin
      s2_last_q        <= s1_last_q;
      s2_tap_q[TAP_C]  <= win1_q[ROW_MID];
      s2_tap_q[TAP_TL] <= (s1_border_q.up && s1_border_q.lf) ? win2_q[ROW_TOP] : '0;
      s2_tap_q[TAP_TR] <= (s1_border_q.up && s1_border_q.rt) ? above : '0;
      s2_tap_q[TAP_BL] <= (s1_border_q.dn && s1_border_q.lf) ? win2_q[ROW_BOT] : '0;
      s2_tap_q[TAP_BR] <= (s1_border_q.dn && s1_border_q.rt) ? s1_pix_q : '0;
    end
    sa_last_q <= s2_last_q;
    sb_last_q <= sa_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      sa_valid_q <= 1'b0;
      sb_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
      sa_valid_q <= s2_valid_q;
      sb_valid_q <= sa_valid_q;
    end
  end

  // --------------------------------------------------------------- weights
  for (genvar t = 0; t < TAPS; t++) begin : g_tap
    for (genvar ch = 0; ch < 3; ch++) begin : g_ch
      dwgf_scale #(
        .CB  (CB),
        .NUM ((t == TAP_C) ? W_CENTRE : W_DIAG),
        .DEN (W_DEN)
      ) u_scale (
        .clk_i (clk_i),
        .v_i   (s2_tap_q[t][ch*CB +: CB]),
        .q_o   (scaled[t][ch])
      );
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_sum
    assign ch_sum[ch] = SW'(scaled[TAP_C][ch]) + SW'(scaled[TAP_TL][ch])
                      + SW'(scaled[TAP_TR][ch]) + SW'(scaled[TAP_BL][ch])
                      + SW'(scaled[TAP_BR][ch]);
    assign res_pix[ch*CB +: CB] = ch_sum[ch][CB-1:0];
  end

  // ---------------------------------------------------------- result queue
  assign push = sb_valid_q;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_mem_q[wptr_q] <= {sb_last_q, res_pix};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q     <= '0;
      rptr_q     <= '0;
      fifo_cnt_q <= '0;
      pending_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + FIFO_AW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + FIFO_CW'(push) - FIFO_CW'(pop);
      pending_q  <= pending_q + FIFO_CW'(adv && emit) - FIFO_CW'(pop);
    end
  end

  assign fifo_rd      = fifo_mem_q[rptr_q];
  assign out_valid_o  = fifo_cnt_q != '0;
  assign out_red_o    = FIELD_BITS'(fifo_rd[2*CB +: CB]);
  assign out_green_o  = FIELD_BITS'(fifo_rd[CB +: CB]);
  assign out_blue_o   = FIELD_BITS'(fifo_rd[0 +: CB]);
  assign frame_last_o = fifo_rd[PW];

`ifndef SYNTHESIS
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= FIFO_CW'(FIFO_DEPTH))
    else $error("results outstanding exceed queue depth");

  a_queue_within_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= pending_q)
    else $error("queue holds more results than were requested");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_row_q <= RW'(dim_q) + RW'(1))
    else $error("input row ran past the drain row");

  a_out_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DW'(out_r_q) < dim_q)
    else $error("output row outside the image");
`endif

endmodule
